/* src/bpi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_pkg
// Shared types and constants for the bicubic pixel interpolator.
// ----------------------------------------------------------------------------
package bpi_pkg;

  localparam int PIX_W        = 8;
  localparam int K_W          = 8;
  localparam int TAPS         = 4;
  localparam int CUBIC_STAGES = 5;

  typedef logic [PIX_W-1:0]             pix_t;
  typedef logic [K_W-1:0]               k_t;
  typedef logic [TAPS-1:0][PIX_W-1:0]   quad_t;
  typedef logic [CUBIC_STAGES-1:0]      stage_en_t;

endpackage
`default_nettype wire

/* src/bpi_cubic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_cubic
// Five-stage Catmull-Rom cubic over four 8-bit taps at offset k/2^FRAC_BITS,
// evaluated exactly, clamped to 0..255 and floored.
// ----------------------------------------------------------------------------
module bpi_cubic #(
  parameter int FRAC_BITS = 8
) (
  input  wire                clk,
  input  bpi_pkg::stage_en_t en,
  input  bpi_pkg::k_t        k,
  input  bpi_pkg::quad_t     q,
  output bpi_pkg::pix_t      res
);
  import bpi_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int N1W   = F + 13;
  localparam int N2W   = 2 * F + 13;
  localparam int N3W   = 3 * F + 13;
  localparam int SHIFT = 3 * F + 1;
  localparam logic [N3W-1:0] TOP_VAL = N3W'(255) << SHIFT;

  logic signed [11:0]    qs [TAPS];
  logic signed [11:0]    a_next;
  logic signed [11:0]    b_next;
  logic signed [11:0]    c_next;

  logic signed [11:0]    a0;
  logic signed [11:0]    b0;
  logic signed [11:0]    c0;
  pix_t                  p1_0;
  k_t                    k0;

  logic signed [N1W-1:0] n1_next;
  logic signed [N1W-1:0] n1;
  logic signed [11:0]    a1;
  pix_t                  p1_1;
  k_t                    k1;

  logic signed [N2W-1:0] n2_next;
  logic signed [N2W-1:0] n2;
  pix_t                  p1_2;
  k_t                    k2;

  logic signed [N3W-1:0] n3_next;
  logic signed [N3W-1:0] n3;
  pix_t                  res_next;

  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      qs[j] = $signed({4'b0000, q[j]});
    end
    a_next = qs[2] - qs[0];
    b_next = (qs[0] <<< 1) - (qs[1] <<< 2) - qs[1] + (qs[2] <<< 2) - qs[3];
    c_next = (qs[1] <<< 1) + qs[1] - (qs[2] <<< 1) - qs[2] + qs[3] - qs[0];
  end

  assign n1_next = ($signed(N1W'(b0)) <<< F)
                 + $signed(N1W'($signed({1'b0, k0}))) * $signed(N1W'(c0));
  assign n2_next = ($signed(N2W'(a1)) <<< (2 * F))
                 + $signed(N2W'($signed({1'b0, k1}))) * $signed(N2W'(n1));
  assign n3_next = ($signed(N3W'(p1_2)) <<< SHIFT)
                 + $signed(N3W'($signed({1'b0, k2}))) * $signed(N3W'(n2));

  always_comb begin
    if (n3[N3W-1]) begin
      res_next = '0;
    end else if ($unsigned(n3) >= TOP_VAL) begin
      res_next = '1;
    end else begin
      res_next = n3[SHIFT +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0   <= a_next;
      b0   <= b_next;
      c0   <= c_next;
      p1_0 <= q[1];
      k0   <= k;
    end
    if (en[1]) begin
      n1   <= n1_next;
      a1   <= a0;
      p1_1 <= p1_0;
      k1   <= k0;
    end
    if (en[2]) begin
      n2   <= n2_next;
      p1_2 <= p1_1;
      k2   <= k1;
    end
    if (en[3]) begin
      n3   <= n3_next;
    end
    if (en[4]) begin
      res  <= res_next;
    end
  end

endmodule
`default_nettype wire

/* src/bicubic_pixel_interpolator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bicubic_pixel_interpolator
// Catmull-Rom bicubic interpolation of a 4x4 pixel neighborhood.
//
// Input channel s_axis: one item carries four packed pixel rows and the
// fractional offsets frac_x and frac_y. Output channel m_axis: one item
// carries the interpolated pixel for each input item, in order.
// Four row cubics in x run side by side, then one column cubic in y.
// Each cubic is five register stages, so the pipeline is ten stages deep;
// one item per cycle is sustained while m_axis_tready is high, and the
// last stage is the output register.
// Each stage has a valid bit; a stage loads whenever it is empty or its
// content moves on, so bubbles close up while m_axis_tready is low and
// s_axis_tready stays high until all ten stages hold items.
// A stall holds full stages past the last bubble; nothing is dropped or repeated.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module bicubic_pixel_interpolator #(
  parameter int FRAC_BITS = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [143:0] s_axis_tdata,   // row_0, row_1, row_2, row_3, frac_x, frac_y
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [7:0]   m_axis_tdata    // pixel_out
);
  import bpi_pkg::*;

  localparam int NST = 2 * CUBIC_STAGES;
  localparam k_t K_MASK = K_W'((33'(1) << FRAC_BITS) - 33'(1));

  logic [NST-1:0] v;
  logic [NST-1:0] ok;
  quad_t          rows   [TAPS];
  quad_t          col_q;
  k_t             kx;
  k_t             ky;
  k_t             ky_pipe [CUBIC_STAGES];
  pix_t           pix_out;

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      ok[i] = m_axis_tready || ((v | NST'((NST'(1) << i) - NST'(1))) != '1);
    end
  end

  assign s_axis_tready = ok[0];
  assign m_axis_tvalid = v[NST-1];
  assign m_axis_tdata  = pix_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ok[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (ok[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign kx = s_axis_tdata[128 +: K_W] & K_MASK;
  assign ky = s_axis_tdata[136 +: K_W] & K_MASK;

  always_ff @(posedge clk) begin
    if (ok[0]) begin
      ky_pipe[0] <= ky;
    end
    for (int i = 1; i < CUBIC_STAGES; i++) begin
      if (ok[i]) begin
        ky_pipe[i] <= ky_pipe[i-1];
      end
    end
  end

  for (genvar r = 0; r < TAPS; r++) begin : g_row
    assign rows[r] = s_axis_tdata[32*r +: 32];

    bpi_cubic #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk (clk),
      .en  (ok[CUBIC_STAGES-1:0]),
      .k   (kx),
      .q   (rows[r]),
      .res (col_q[r])
    );
  end

  bpi_cubic #(
    .FRAC_BITS (FRAC_BITS)
  ) u_col (
    .clk (clk),
    .en  (ok[NST-1:CUBIC_STAGES]),
    .k   (ky_pipe[CUBIC_STAGES-1]),
    .q   (col_q),
    .res (pix_out)
  );

  a_take_fills_first : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v[0])
    else $error("accepted item did not enter the first stage");

  a_bubble_ready : assert property (@(posedge clk) disable iff (rst)
    (v != '1) |-> s_axis_tready)
    else $error("input stalled while the pipeline has an empty stage");

  a_count_moves : assert property (@(posedge clk) disable iff (rst)
    (!s_axis_tvalid && !m_axis_tready) |=> ($countones(v) == $past($countones(v))))
    else $error("items created or lost while held");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
